@@ rtl/core/dhb_pwm_pkg.sv @@
// package for the dual h-bridge pwm driver
// command codes, duty constants, beat widths and the duty function shared by the core
// no dependencies
package dhb_pwm_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_POWER = 2'd1,
      CMD_BRAKE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam int DUTY_W      = 4;
   localparam int WIDTH_W     = 8;
   localparam int POWER_W     = 8;
   localparam int OUT_W       = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 3;

   localparam logic [DUTY_W-1:0]  FULL_DUTY      = 4'd10;
   localparam logic [WIDTH_W-1:0] PWM_WIDTH_RST  = 8'd10;
   localparam int                 DUTY_ROUND     = 5;
   localparam int                 DUTY_STEP      = 10;
   localparam int                 RECIP_SHIFT    = 11;
   localparam int                 RECIP          = (2**RECIP_SHIFT + DUTY_STEP - 1) / DUTY_STEP;

   typedef logic [DUTY_W-1:0] duty_type;

   // (|power| + 5) / 10, clamped to full duty
   function automatic duty_type duty_of(input logic signed [POWER_W-1:0] power);
      logic [POWER_W-1:0]   mag;
      logic [POWER_W-1:0]   rounded;
      logic [2*POWER_W-1:0] prod;
      logic [POWER_W-1:0]   quot;
      mag     = power[POWER_W-1] ? (~power + 1'b1) : power;
      rounded = mag + POWER_W'(DUTY_ROUND);
      prod    = rounded * POWER_W'(RECIP);
      quot    = POWER_W'(prod >> RECIP_SHIFT);
      if (quot > POWER_W'(FULL_DUTY)) begin
         return FULL_DUTY;
      end
      return quot[DUTY_W-1:0];
   endfunction

endpackage

@@ rtl/core/dual_hbridge_pwm_driver_unit.sv @@
// Dual H-bridge PWM driver. Every request beat is a tick, a set-power, a
// set-brake or an unused no-op command and returns exactly one response beat
// with the four bridge line levels and an idle flag, taken after the command
// has been applied. One beat is taken per clock cycle unless skid is full;
// the state update and the level compares sit between the request handshake
// and the response register, and a two-entry output stage lets a new beat in
// while a response is still held by the sink. Write csr_wr_data to set the
// PWM period (ticks before the shared counter wraps) only while idle.
//
// top level of the dual h-bridge pwm driver
// depends on dhb_pwm_pkg
module dual_hbridge_pwm_driver_unit
   import dhb_pwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // power[7:0], brake_on[8], zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,   // cmd[1:0], motor[2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,   // m0_forward, m0_reverse, m1_forward,
                                              // m1_reverse, motors_idle, zero pad
   input  logic                  csr_wr_en,
   input  logic [WIDTH_W-1:0]    csr_wr_data
);

   logic [WIDTH_W-1:0] pwm_width_ff;
   logic [WIDTH_W-1:0] tick_ff, tick_in;
   duty_type           fwd_ff [2];
   duty_type           fwd_in [2];
   duty_type           rev_ff [2];
   duty_type           rev_in [2];
   logic [1:0]         live_ff, live_in;

   logic               out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]   out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [OUT_W-1:0]   skid_data_ff, skid_data_in;

   logic               accept;
   logic               pop;
   cmd_type            cmd;
   logic               motor;
   logic signed [POWER_W-1:0] power;
   logic               brake_on;
   duty_type           duty;
   logic [WIDTH_W:0]   tick_next;
   logic [OUT_W-1:0]   result;

   assign cmd      = cmd_type'(req_tuser[1:0]);
   assign motor    = req_tuser[2];
   assign power    = req_tdata[POWER_W-1:0];
   assign brake_on = req_tdata[POWER_W];
   assign duty     = duty_of(power);

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      tick_in   = tick_ff;
      fwd_in    = fwd_ff;
      rev_in    = rev_ff;
      live_in   = live_ff;
      tick_next = {1'b0, tick_ff} + 1'b1;
      if (accept) begin
         case (cmd)
            CMD_TICK: begin
               tick_in = (tick_next >= {1'b0, pwm_width_ff}) ? '0 : tick_next[WIDTH_W-1:0];
            end
            CMD_POWER: begin
               live_in[motor] = (power != '0);
               fwd_in[motor]  = power[POWER_W-1] ? '0 : duty;
               rev_in[motor]  = power[POWER_W-1] ? duty : '0;
            end
            CMD_BRAKE: begin
               live_in[motor] = 1'b0;
               fwd_in[motor]  = brake_on ? FULL_DUTY : '0;
               rev_in[motor]  = brake_on ? FULL_DUTY : '0;
            end
            default: begin
            end
         endcase
      end
      result = {3'b000,
                live_in == 2'b00,
                WIDTH_W'(rev_in[1]) > tick_in,
                WIDTH_W'(fwd_in[1]) > tick_in,
                WIDTH_W'(rev_in[0]) > tick_in,
                WIDTH_W'(fwd_in[0]) > tick_in};
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_width_ff  <= PWM_WIDTH_RST;
         tick_ff       <= '0;
         fwd_ff        <= '{default: '0};
         rev_ff        <= '{default: '0};
         live_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pwm_width_ff <= csr_wr_data;
         end
         tick_ff       <= tick_in;
         fwd_ff        <= fwd_in;
         rev_ff        <= rev_in;
         live_ff       <= live_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

@@ tb/dhb_line_check_pkg.sv @@
// line-level tracker for the dual h-bridge pwm driver testbench
// predicts the four bridge lines and the idle flag per request beat and checks response beats
// depends on dhb_pwm_pkg
package dhb_line_check_pkg;
   import dhb_pwm_pkg::*;

   typedef struct packed {
      logic m0_forward;
      logic m0_reverse;
      logic m1_forward;
      logic m1_reverse;
      logic motors_idle;
   } line_levels_type;

   class bridge_line_tracker;
      logic [WIDTH_W-1:0]        pwm_width;
      logic [WIDTH_W-1:0]        tick_count;
      duty_type                  fwd_duty[2];
      duty_type                  rev_duty[2];
      logic signed [POWER_W-1:0] motor_power[2];
      line_levels_type           expected_levels[$];
      int                        mismatches;

      function new();
         pwm_width   = PWM_WIDTH_RST;
         tick_count  = '0;
         mismatches  = 0;
         for (int i = 0; i < 2; i++) begin
            fwd_duty[i]    = '0;
            rev_duty[i]    = '0;
            motor_power[i] = '0;
         end
      endfunction

      function void load_pwm_width(logic [WIDTH_W-1:0] width);
         pwm_width = width;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function duty_type power_to_duty(logic signed [POWER_W-1:0] power);
         int mag;
         int duty;
         mag  = (power < 0) ? -int'(power) : int'(power);
         duty = (mag + 5) / 10;
         if (duty > int'(FULL_DUTY)) begin
            duty = int'(FULL_DUTY);
         end
         return duty_type'(duty);
      endfunction

      function void note_request(cmd_type cmd, bit motor, logic signed [POWER_W-1:0] power,
                                 bit brake_on);
         int              next_tick;
         int              m;
         line_levels_type lv;
         m = motor;
         case (cmd)
            CMD_TICK: begin
               next_tick = int'(tick_count) + 1;
               if (next_tick >= int'(pwm_width)) begin
                  next_tick = 0;
               end
               tick_count = WIDTH_W'(next_tick);
            end
            CMD_POWER: begin
               motor_power[m] = power;
               fwd_duty[m]    = (power > 0) ? power_to_duty(power) : '0;
               rev_duty[m]    = (power < 0) ? power_to_duty(power) : '0;
            end
            CMD_BRAKE: begin
               motor_power[m] = '0;
               fwd_duty[m]    = brake_on ? FULL_DUTY : '0;
               rev_duty[m]    = brake_on ? FULL_DUTY : '0;
            end
            default: ;
         endcase
         lv.m0_forward  = WIDTH_W'(fwd_duty[0]) > tick_count;
         lv.m0_reverse  = WIDTH_W'(rev_duty[0]) > tick_count;
         lv.m1_forward  = WIDTH_W'(fwd_duty[1]) > tick_count;
         lv.m1_reverse  = WIDTH_W'(rev_duty[1]) > tick_count;
         lv.motors_idle = (motor_power[0] == 0) && (motor_power[1] == 0);
         expected_levels.push_back(lv);
      endfunction

      function void compare_line(string field, logic expected, logic actual);
         if (actual !== expected) begin
            $error("%s mismatch: expected %b, actual %b", field, expected, actual);
            mismatches++;
         end
      endfunction

      function void check_levels(logic [OUT_W-1:0] data);
         line_levels_type lv;
         if (expected_levels.size() == 0) begin
            $error("response beat %h with nothing expected", data);
            mismatches++;
            return;
         end
         lv = expected_levels.pop_front();
         compare_line("m0_forward", lv.m0_forward, data[0]);
         compare_line("m0_reverse", lv.m0_reverse, data[1]);
         compare_line("m1_forward", lv.m1_forward, data[2]);
         compare_line("m1_reverse", lv.m1_reverse, data[3]);
         compare_line("motors_idle", lv.motors_idle, data[4]);
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// top-level testbench for dual_hbridge_pwm_driver_unit
// drives command beats with random gaps and sink stalls, checks every response beat
// depends on dhb_pwm_pkg and dhb_line_check_pkg
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dhb_pwm_pkg::*;
   import dhb_line_check_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [WIDTH_W-1:0]    csr_wr_data = '0;

   bridge_line_tracker tracker;
   int                 sent_count  = 0;
   int                 rsp_count   = 0;
   int                 quiet_count = 0;

   dual_hbridge_pwm_driver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_item(cmd_type cmd, bit motor, logic [POWER_W-1:0] power, bit brake_on);
      @(negedge clock);
      while (!(sent_count >= 400 && sent_count < 550) && $urandom_range(99) < 36) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = {motor, cmd};
      req_tdata  = {7'd0, brake_on, power};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(cmd, motor, power, brake_on);
      sent_count++;
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, 1'($urandom_range(1)), POWER_W'($urandom_range(255)),
                1'($urandom_range(1)));
   endtask

   task automatic send_random_item();
      int                 pick;
      cmd_type            cmd;
      logic [POWER_W-1:0] power;
      pick = $urandom_range(99);
      if (pick < 45) begin
         cmd = CMD_TICK;
      end else if (pick < 78) begin
         cmd = CMD_POWER;
      end else if (pick < 92) begin
         cmd = CMD_BRAKE;
      end else begin
         cmd = CMD_NONE;
      end
      if ($urandom_range(1)) begin
         power = POWER_W'($urandom_range(255));
      end else begin
         power = POWER_W'($urandom_range(30));
         if ($urandom_range(1)) begin
            power = -power;
         end
      end
      send_item(cmd, 1'($urandom_range(1)), power, 1'($urandom_range(1)));
   endtask

   task automatic set_pwm_width(logic [WIDTH_W-1:0] width);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = width;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tracker.load_pwm_width(width);
   endtask

   // sink: random stalls, a clean stretch and one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_count >= 650) begin
            hold_done = 1'b1;
            hold_left = 64;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (rsp_count >= 100 && rsp_count < 250) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(99) >= 36);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_levels(rsp_tdata);
            rsp_count++;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
            if (quiet_count >= STALL_LIMIT) begin
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default width, power rounding and clamping, brake, unused command
      send_item(CMD_TICK, 1'b1, 8'hFF, 1'b1);
      send_item(CMD_POWER, 1'b0, 8'd127, 1'b1);
      send_item(CMD_POWER, 1'b1, 8'h80, 1'b0);
      send_item(CMD_POWER, 1'b0, 8'd0, 1'b1);
      send_item(CMD_POWER, 1'b1, 8'd1, 1'b0);
      send_item(CMD_POWER, 1'b0, 8'd4, 1'b0);
      send_item(CMD_POWER, 1'b0, 8'd5, 1'b1);
      send_item(CMD_POWER, 1'b1, -8'sd5, 1'b0);
      send_item(CMD_POWER, 1'b1, -8'sd14, 1'b1);
      send_item(CMD_POWER, 1'b0, 8'd15, 1'b0);
      send_item(CMD_POWER, 1'b0, 8'd94, 1'b0);
      send_item(CMD_POWER, 1'b1, 8'd95, 1'b0);
      send_item(CMD_NONE, 1'b1, 8'h55, 1'b1);
      send_item(CMD_BRAKE, 1'b0, 8'h7F, 1'b1);
      send_item(CMD_BRAKE, 1'b1, 8'h80, 1'b1);
      repeat (10) send_tick();
      send_item(CMD_BRAKE, 1'b0, 8'h00, 1'b0);
      send_item(CMD_BRAKE, 1'b1, 8'hFF, 1'b0);

      // zero width holds the counter at zero
      set_pwm_width(8'd0);
      send_item(CMD_POWER, 1'b0, -8'sd60, 1'b0);
      send_tick();
      send_item(CMD_BRAKE, 1'b1, 8'd0, 1'b1);
      send_tick();

      // width lowered below the running counter
      set_pwm_width(8'd200);
      repeat (60) send_tick();
      set_pwm_width(8'd20);
      send_tick();
      send_item(CMD_POWER, 1'b0, 8'd100, 1'b0);
      send_tick();

      // widest period, full counter wrap
      set_pwm_width(8'd255);
      send_item(CMD_POWER, 1'b1, -8'sd30, 1'b0);
      repeat (256) send_tick();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       set_pwm_width(8'd1);
            1:       set_pwm_width(8'd255);
            2:       set_pwm_width(8'd0);
            3:       set_pwm_width(WIDTH_W'($urandom_range(255)));
            default: set_pwm_width(WIDTH_W'($urandom_range(2, 14)));
         endcase
         repeat (35) send_random_item();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
